// ===== src/chunk_tile_map_parser_unit_defines.svh =====
// Assertion macros for the chunk tile map parser.
// Included by the top level; each macro expects signals clk and rst in scope.
`ifndef CHUNK_TILE_MAP_PARSER_UNIT_DEFINES_SVH
`define CHUNK_TILE_MAP_PARSER_UNIT_DEFINES_SVH

// A condition that holds at every clock edge outside reset.
`define CTMP_ASSERT_HOLDS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A condition that implies another in the same cycle.
`define CTMP_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// A condition that implies another in the following cycle.
`define CTMP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/ctmp_pkg.sv =====
// Shared constants, codes and types of the chunk tile map parser.
// No dependencies; the result queue, the top level and the testbench import this package.
package ctmp_pkg;

  // Grid geometry default.
  localparam int unsigned GRID_SIDE_DEFAULT = 64;

  // File format constants.
  localparam logic [31:0] TAG_VERSION       = 32'h4D56_4552;
  localparam logic [31:0] TAG_GRID          = 32'h4D41_494E;
  localparam logic [31:0] HEADER_VERSION    = 32'd18;
  localparam logic [31:0] MIN_LENGTH        = 32'd12;
  localparam logic [31:0] LENGTH_RESET      = 32'd12;
  localparam logic [31:0] POS_TAG_CHECK     = 32'd3;
  localparam logic [31:0] POS_VERSION_CHECK = 32'd11;
  localparam logic [31:0] WORD_LAST_BYTE    = 32'd3;
  localparam logic [2:0]  CELL_FLAG_BYTE    = 3'd3;

  // Presence map storage.
  localparam int unsigned MAP_WORD_BITS = 64;
  localparam int unsigned MAP_BIT_W     = 6;

  // Result queue.
  localparam int unsigned OUT_DEPTH = 4;
  localparam int unsigned OUT_CNT_W = 3;

  // Configuration port.
  localparam int unsigned PADDR_W = 3;
  localparam logic REG_STREAM_LENGTH = 1'b0;

  typedef enum logic [2:0] {
    PH_TAG     = 3'b001,
    PH_SIZE    = 3'b010,
    PH_PAYLOAD = 3'b100
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_TOO_SHORT   = 2'd1,
    ST_BAD_TAG     = 2'd2,
    ST_BAD_VERSION = 2'd3
  } status_t;

  typedef enum logic {
    KIND_CELL   = 1'b0,
    KIND_STATUS = 1'b1
  } kind_t;

  typedef struct packed {
    logic        result_kind;
    logic [11:0] cell_index;
    logic        cell_present;
    logic [1:0]  parse_status;
    logic        is_last;
  } result_t;

  typedef struct packed {
    logic [OUT_CNT_W-1:0] count;
    logic                 empty;
  } fifo_status_t;

endpackage

// ===== src/ctmp_ifs.sv =====
// Handshake channel interfaces: file bytes in, result items out.
// Depends on nothing; payload widths are fixed by the file format.
interface ctmp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface ctmp_result_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [11:0] cell_index;
  logic        cell_present;
  logic [1:0]  parse_status;
  logic        is_last;

  modport source (output valid, output result_kind, output cell_index,
                  output cell_present, output parse_status, output is_last,
                  input ready);
  modport sink (input valid, input result_kind, input cell_index,
                input cell_present, input parse_status, input is_last,
                output ready);
endinterface

// ===== src/ctmp_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read.
// Depends on nothing.
module ctmp_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/ctmp_result_fifo.sv =====
// Small result queue: up to two items pushed and one popped per cycle.
// Depends on ctmp_pkg for the result and status types.
module ctmp_result_fifo import ctmp_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         push_a_v,
  input  result_t      push_a,
  input  logic         push_b_v,
  input  result_t      push_b,
  output logic         out_valid,
  output result_t      out_data,
  input  logic         out_ready,
  output fifo_status_t status
);

  localparam int unsigned PW = $clog2(OUT_DEPTH);

  result_t              slots [OUT_DEPTH];
  logic [PW-1:0]        wr_ptr;
  logic [PW-1:0]        rd_ptr;
  logic [OUT_CNT_W-1:0] count;
  logic                 any_push;
  logic                 both_push;
  logic                 pop;
  logic [OUT_CNT_W-1:0] push_n;
  result_t              first;

  // When only the second source pushes, it takes the first free slot.
  assign any_push  = push_a_v | push_b_v;
  assign both_push = push_a_v & push_b_v;
  assign first     = push_a_v ? push_a : push_b;
  assign push_n    = OUT_CNT_W'(any_push) + OUT_CNT_W'(both_push);
  assign pop       = out_valid && out_ready;

  assign out_valid = (count != '0);
  assign out_data  = slots[rd_ptr];
  assign status    = '{count: count, empty: (count == '0)};

  // Payload slots.
  always_ff @(posedge clk) begin
    if (any_push) begin
      slots[wr_ptr] <= first;
    end
    if (both_push) begin
      slots[wr_ptr + PW'(1)] <= push_b;
    end
  end

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + push_n[PW-1:0];
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      count <= count + push_n - OUT_CNT_W'(pop);
    end
  end

endmodule

// ===== src/chunk_tile_map_parser_unit.sv =====
// Top level of the chunk tile map parser: byte walker, presence map, results.
// Depends on ctmp_pkg, ctmp_ifs, ctmp_ram, ctmp_result_fifo and the defines header.
//
//   channel     | direction | handshake          | payload
//   byte_in     | in        | valid/ready        | data_byte
//   result_out  | out       | valid/ready        | result_kind, cell_index, cell_present,
//               |           |                    | parse_status, is_last
//   apb         | in        | psel/penable/pready| paddr, pwdata, prdata (stream_length)
//
// One byte item is taken per cycle when ready; its results are registered, then queued.
// The presence map is a RAM of 64-bit words, ceil(GRID_SIDE*GRID_SIDE/64) deep
// (64 at the default side); a cell update is a read, then a write in the next cycle.
// After reset and after every good header the map is swept to zero, one word a
// cycle; no byte item is taken during the sweep. Byte items also wait while
// the four-entry result queue cannot take two more items.
`include "chunk_tile_map_parser_unit_defines.svh"

module chunk_tile_map_parser_unit import ctmp_pkg::*; #(
  parameter int unsigned GRID_SIDE = GRID_SIDE_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  ctmp_byte_if.sink          byte_in,
  ctmp_result_if.source      result_out,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int unsigned CELL_COUNT = GRID_SIDE * GRID_SIDE;
  localparam int unsigned MAP_WORDS  = (CELL_COUNT + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
  localparam int unsigned MAP_AW     = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

  // Configuration and per-file state.
  logic [31:0] stream_length;
  logic [31:0] byte_position;
  phase_t      chunk_phase;
  logic [31:0] chunk_offset;
  logic [31:0] chunk_length;
  logic [31:0] word_gather;
  logic        chunk_is_grid;
  status_t     header_failure;
  logic        stopped;

  // Map clearing sweep.
  logic              clearing;
  logic [MAP_AW-1:0] clear_addr;

  // Second stage: map read data returns here.
  logic                     s1_cell_v;
  logic                     s1_set;
  logic [MAP_AW-1:0]        s1_word;
  logic [MAP_BIT_W-1:0]     s1_bit;
  logic [11:0]              s1_index;
  logic                     s1_eof_v;
  status_t                  s1_status;

  // First stage decode.
  logic        in_acc;
  logic [31:0] wg_next;
  logic        len_ok;
  status_t     hf_step;
  logic        stop_step;
  logic        clear_req;
  phase_t      phase_next;
  logic [31:0] off_inc;
  logic [31:0] off_next;
  logic [31:0] len_next;
  logic        grid_next;
  logic        cell_hit;
  logic        cell_in_grid;
  logic        cell_fits;
  logic        overrun;
  logic        eof;

  // Map RAM and result queue wiring.
  logic                     map_we;
  logic [MAP_AW-1:0]        map_waddr;
  logic [MAP_WORD_BITS-1:0] map_wdata;
  logic [MAP_WORD_BITS-1:0] map_rdata;
  logic [MAP_WORD_BITS-1:0] merged_word;
  logic                     cell_present;
  result_t                  cell_result;
  result_t                  status_result;
  result_t                  head;
  fifo_status_t             q_status;
  logic [OUT_CNT_W:0]       q_load;

  // Configuration port: writes land at the access phase.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_STREAM_LENGTH) ? stream_length : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      stream_length <= LENGTH_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_STREAM_LENGTH) begin
      stream_length <= pwdata;
    end
  end

  // Input is held while sweeping or while the queue could not take two items.
  assign q_load       = (OUT_CNT_W + 1)'(q_status.count) + (OUT_CNT_W + 1)'(s1_cell_v)
                        + (OUT_CNT_W + 1)'(s1_eof_v);
  assign byte_in.ready = !clearing && (q_load <= (OUT_CNT_W + 1)'(OUT_DEPTH - 2));
  assign in_acc        = byte_in.valid && byte_in.ready;

  // Wide compares for the current byte.
  assign wg_next      = {byte_in.data_byte, word_gather[31:8]};
  assign len_ok       = (stream_length >= MIN_LENGTH);
  assign off_inc      = chunk_offset + 32'd1;
  assign overrun      = ({1'b0, byte_position} + 33'd1 + {1'b0, wg_next})
                        > {1'b0, stream_length};
  assign cell_in_grid = ({3'b000, chunk_offset[31:3]} < 32'(CELL_COUNT));
  assign cell_fits    = ({1'b0, chunk_offset[31:3], 3'b000} + 33'd8) <= {1'b0, chunk_length};
  assign eof          = ({1'b0, byte_position} + 33'd1) >= {1'b0, stream_length};

  // Header checks and the chunk walker.
  always_comb begin
    hf_step    = header_failure;
    stop_step  = stopped;
    clear_req  = 1'b0;
    phase_next = chunk_phase;
    off_next   = chunk_offset;
    len_next   = chunk_length;
    grid_next  = chunk_is_grid;
    cell_hit   = 1'b0;

    if (byte_position == POS_TAG_CHECK && header_failure == ST_OK
        && wg_next != TAG_VERSION) begin
      hf_step   = ST_BAD_TAG;
      stop_step = 1'b1;
    end
    if (byte_position == POS_VERSION_CHECK && hf_step == ST_OK && len_ok) begin
      if (wg_next != HEADER_VERSION) begin
        hf_step   = ST_BAD_VERSION;
        stop_step = 1'b1;
      end else begin
        clear_req = 1'b1;
      end
    end

    if (!stop_step) begin
      case (chunk_phase)
        PH_TAG: begin
          if (chunk_offset == WORD_LAST_BYTE) begin
            grid_next  = (wg_next == TAG_GRID);
            phase_next = PH_SIZE;
            off_next   = '0;
          end else begin
            off_next = off_inc;
          end
        end
        PH_SIZE: begin
          if (chunk_offset == WORD_LAST_BYTE) begin
            len_next = wg_next;
            off_next = '0;
            if (overrun) begin
              stop_step = 1'b1;
            end else if (wg_next == '0) begin
              phase_next = PH_TAG;
            end else begin
              phase_next = PH_PAYLOAD;
            end
          end else begin
            off_next = off_inc;
          end
        end
        PH_PAYLOAD: begin
          cell_hit = chunk_is_grid && chunk_offset[2:0] == CELL_FLAG_BYTE
                     && hf_step == ST_OK && len_ok && cell_in_grid && cell_fits;
          off_next = off_inc;
          if (off_inc == chunk_length) begin
            phase_next = PH_TAG;
            off_next   = '0;
          end
        end
        default: begin
          phase_next = PH_TAG;
        end
      endcase
    end
  end

  // Per-file state; the end of a file returns everything but the map to reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position  <= '0;
      chunk_phase    <= PH_TAG;
      chunk_offset   <= '0;
      chunk_length   <= '0;
      word_gather    <= '0;
      chunk_is_grid  <= 1'b0;
      header_failure <= ST_OK;
      stopped        <= 1'b0;
    end else if (in_acc) begin
      if (eof) begin
        byte_position  <= '0;
        chunk_phase    <= PH_TAG;
        chunk_offset   <= '0;
        chunk_length   <= '0;
        word_gather    <= '0;
        chunk_is_grid  <= 1'b0;
        header_failure <= ST_OK;
        stopped        <= 1'b0;
      end else begin
        byte_position  <= byte_position + 32'd1;
        chunk_phase    <= phase_next;
        chunk_offset   <= off_next;
        chunk_length   <= len_next;
        word_gather    <= wg_next;
        chunk_is_grid  <= grid_next;
        header_failure <= hf_step;
        stopped        <= stop_step;
      end
    end
  end

  // Clearing sweep, started by reset and by every good header.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing   <= 1'b1;
      clear_addr <= '0;
    end else if (clearing) begin
      if (clear_addr == MAP_AW'(MAP_WORDS - 1)) begin
        clearing <= 1'b0;
      end
      clear_addr <= clear_addr + MAP_AW'(1);
    end else if (in_acc && clear_req) begin
      clearing   <= 1'b1;
      clear_addr <= '0;
    end
  end

  // Second stage control; cell updates are at least eight bytes apart, so a
  // write-back always completes before the next read of the map.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_cell_v <= 1'b0;
      s1_eof_v  <= 1'b0;
    end else begin
      s1_cell_v <= in_acc && cell_hit;
      s1_eof_v  <= in_acc && eof;
    end
  end

  // Second stage payload.
  always_ff @(posedge clk) begin
    s1_set    <= wg_next[0];
    s1_word   <= chunk_offset[9 +: MAP_AW];
    s1_bit    <= chunk_offset[8:3];
    s1_index  <= chunk_offset[14:3];
    s1_status <= len_ok ? hf_step : ST_TOO_SHORT;
  end

  // Merge the flag into the word that came back and write it home when the flag is set.
  assign merged_word  = map_rdata | (MAP_WORD_BITS'(s1_set) << s1_bit);
  assign cell_present = merged_word[s1_bit];
  assign map_we       = clearing || (s1_cell_v && s1_set);
  assign map_waddr    = clearing ? clear_addr : s1_word;
  assign map_wdata    = clearing ? '0 : merged_word;

  ctmp_ram #(
    .WIDTH (MAP_WORD_BITS),
    .DEPTH (MAP_WORDS)
  ) u_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .re    (in_acc && cell_hit),
    .raddr (chunk_offset[9 +: MAP_AW]),
    .rdata (map_rdata)
  );

  // Result items: a cell report goes ahead of the status of the same byte.
  assign cell_result = '{result_kind: KIND_CELL, cell_index: s1_index,
                         cell_present: cell_present, parse_status: ST_OK, is_last: 1'b0};
  assign status_result = '{result_kind: KIND_STATUS, cell_index: 12'd0,
                           cell_present: 1'b0, parse_status: s1_status, is_last: 1'b1};

  ctmp_result_fifo u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_a_v  (s1_cell_v),
    .push_a    (cell_result),
    .push_b_v  (s1_eof_v),
    .push_b    (status_result),
    .out_valid (result_out.valid),
    .out_data  (head),
    .out_ready (result_out.ready),
    .status    (q_status)
  );

  assign result_out.result_kind  = head.result_kind;
  assign result_out.cell_index   = head.cell_index;
  assign result_out.cell_present = head.cell_present;
  assign result_out.parse_status = head.parse_status;
  assign result_out.is_last      = head.is_last;

  // Checks on the map pipeline, the file restart and the result queue bound.
  `CTMP_ASSERT_IMPLIES(a_no_sweep_collision, s1_cell_v, !clearing, "cell update during map sweep")
  `CTMP_ASSERT_NEXT(a_eof_restart, in_acc && eof, byte_position == '0 && !stopped, "file state not restarted")
  `CTMP_ASSERT_HOLDS(a_queue_bound, q_status.count <= OUT_CNT_W'(OUT_DEPTH), "result queue overflow")

endmodule

// ===== verif/tb_chunk_tile_map_parser_unit.sv =====
// Self-checking testbench for chunk_tile_map_parser_unit: streams tile map files byte by byte.
// Checks every result item against an in-bench byte walker. Depends on ctmp_pkg and ctmp_ifs.
module tb_chunk_tile_map_parser_unit;
  import ctmp_pkg::*;

  localparam int unsigned GRID = GRID_SIDE_DEFAULT;
  localparam int unsigned CELLS = GRID * GRID;
  localparam int unsigned SETTLE_CYCLES = 100;
  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam logic [PADDR_W-1:0] LEN_ADDR = PADDR_W'({REG_STREAM_LENGTH, 2'b00});

  typedef enum logic [1:0] {
    FILE_GOOD, FILE_BAD_TAG, FILE_BAD_VERSION, FILE_NOISE
  } file_kind_t;

  typedef enum logic [1:0] {
    FLAG_RANDOM, FLAG_SET, FLAG_CLEAR
  } flag_mode_t;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  ctmp_byte_if byte_ch ();
  ctmp_result_if result_ch ();

  chunk_tile_map_parser_unit #(.GRID_SIDE(GRID)) u_dut (
    .clk        (clk),
    .rst        (rst),
    .byte_in    (byte_ch),
    .result_out (result_ch),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // File bytes waiting to be sent, and the results the walker says are due.
  logic [7:0] file_bytes[$];
  result_t parser_results_due[$];
  int unsigned bytes_loaded = 0;
  int unsigned bytes_taken = 0;
  int unsigned bad_results = 0;
  int unsigned cycle_count = 0;
  logic byte_taken = 1'b0;
  logic no_idle = 1'b0;
  int unsigned send_gap = 0;
  int unsigned recv_gap = 0;

  // Walker copy of the parser state and of the length register.
  logic [31:0] length_copy;
  logic [31:0] walk_pos;
  logic [31:0] chunk_off;
  logic [31:0] chunk_len;
  logic [31:0] gather;
  phase_t walk_phase;
  logic in_grid;
  status_t hdr_status;
  logic halted;
  logic presence[CELLS];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void restart_walk();
    walk_pos = '0;
    walk_phase = PH_TAG;
    chunk_off = '0;
    chunk_len = '0;
    gather = '0;
    in_grid = 1'b0;
    hdr_status = ST_OK;
    halted = 1'b0;
  endfunction

  function automatic void clear_presence();
    foreach (presence[i]) presence[i] = 1'b0;
  endfunction

  // Advance the walker by one file byte and queue the results it yields.
  function automatic void walk_file_byte(input logic [7:0] b);
    logic [31:0] cell_num;
    result_t r;
    gather = {b, gather[31:8]};

    // Header checks: tag at the first word, version at the third.
    if (walk_pos == POS_TAG_CHECK && hdr_status == ST_OK && gather != TAG_VERSION) begin
      hdr_status = ST_BAD_TAG;
      halted = 1'b1;
    end
    if (walk_pos == POS_VERSION_CHECK && hdr_status == ST_OK && length_copy >= MIN_LENGTH) begin
      if (gather != HEADER_VERSION) begin
        hdr_status = ST_BAD_VERSION;
        halted = 1'b1;
      end else begin
        clear_presence();
      end
    end

    // Chunk walk: tag word, size word, then payload.
    if (!halted) begin
      case (walk_phase)
        PH_TAG: begin
          if (chunk_off == WORD_LAST_BYTE) begin
            in_grid = (gather == TAG_GRID);
            walk_phase = PH_SIZE;
            chunk_off = '0;
          end else begin
            chunk_off++;
          end
        end
        PH_SIZE: begin
          if (chunk_off == WORD_LAST_BYTE) begin
            chunk_len = gather;
            chunk_off = '0;
            if ({32'd0, walk_pos} + 64'd1 + {32'd0, chunk_len} > {32'd0, length_copy}) begin
              halted = 1'b1;
            end else if (chunk_len == 0) begin
              walk_phase = PH_TAG;
            end else begin
              walk_phase = PH_PAYLOAD;
            end
          end else begin
            chunk_off++;
          end
        end
        default: begin
          cell_num = chunk_off >> 3;
          if (in_grid && chunk_off[2:0] == CELL_FLAG_BYTE && hdr_status == ST_OK
              && length_copy >= MIN_LENGTH && cell_num < CELLS
              && ({32'd0, cell_num} + 64'd1) * 64'd8 <= {32'd0, chunk_len}) begin
            if (gather[0]) presence[cell_num] = 1'b1;
            r.result_kind = KIND_CELL;
            r.cell_index = cell_num[11:0];
            r.cell_present = presence[cell_num];
            r.parse_status = ST_OK;
            r.is_last = 1'b0;
            parser_results_due.push_back(r);
          end
          chunk_off++;
          if (chunk_off == chunk_len) begin
            walk_phase = PH_TAG;
            chunk_off = '0;
          end
        end
      endcase
    end

    // End of file: report status and start over; the map is kept.
    if ({32'd0, walk_pos} + 64'd1 >= {32'd0, length_copy}) begin
      r.result_kind = KIND_STATUS;
      r.cell_index = '0;
      r.cell_present = 1'b0;
      r.parse_status = (length_copy < MIN_LENGTH) ? ST_TOO_SHORT : hdr_status;
      r.is_last = 1'b1;
      parser_results_due.push_back(r);
      restart_walk();
    end else begin
      walk_pos++;
    end
  endfunction

  // Byte sender: holds an item until taken, with random idle bursts.
  always @(negedge clk) begin
    if (rst) begin
      byte_ch.valid <= 1'b0;
    end else if (!byte_ch.valid || byte_taken) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        byte_ch.valid <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 9) == 0) begin
        send_gap <= $urandom_range(0, 10);
        byte_ch.valid <= 1'b0;
      end else if (file_bytes.size() > 0) begin
        byte_ch.data_byte <= file_bytes.pop_front();
        byte_ch.valid <= 1'b1;
      end else begin
        byte_ch.valid <= 1'b0;
      end
    end
  end

  // Result receiver: stalls in random bursts.
  always @(negedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap <= recv_gap - 1;
      result_ch.ready <= 1'b0;
    end else if (!no_idle && $urandom_range(0, 7) == 0) begin
      recv_gap <= $urandom_range(0, 10);
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= 1'b1;
    end
  end

  // Monitor: track register writes, walk accepted bytes, check each result item.
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst) begin
      byte_taken <= 1'b0;
      length_copy = LENGTH_RESET;
      restart_walk();
      clear_presence();
    end else begin
      byte_taken <= byte_ch.valid && byte_ch.ready;
      if (psel && penable && pwrite && pready && paddr == LEN_ADDR) length_copy = pwdata;
      if (byte_ch.valid && byte_ch.ready) begin
        walk_file_byte(byte_ch.data_byte);
        bytes_taken++;
      end
      if (result_ch.valid && result_ch.ready) begin
        got.result_kind = result_ch.result_kind;
        got.cell_index = result_ch.cell_index;
        got.cell_present = result_ch.cell_present;
        got.parse_status = result_ch.parse_status;
        got.is_last = result_ch.is_last;
        if (parser_results_due.size() == 0) begin
          bad_results++;
          $display("%0t: result with nothing due: kind=%0d cell=%0d present=%0d status=%0d last=%0d",
                   $time, got.result_kind, got.cell_index, got.cell_present,
                   got.parse_status, got.is_last);
        end else begin
          want = parser_results_due.pop_front();
          if (got !== want) begin
            bad_results++;
            $display({"%0t: result mismatch: expected kind=%0d cell=%0d present=%0d ",
                      "status=%0d last=%0d, got kind=%0d cell=%0d present=%0d status=%0d last=%0d"},
                     $time, want.result_kind, want.cell_index, want.cell_present,
                     want.parse_status, want.is_last, got.result_kind, got.cell_index,
                     got.cell_present, got.parse_status, got.is_last);
          end
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: run timed out after %0d cycles", $time, cycle_count);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic put_byte(input logic [7:0] b);
    file_bytes.push_back(b);
    bytes_loaded++;
  endtask

  // Little-endian word, as the file stores it.
  task automatic put_word(input logic [31:0] w);
    for (int i = 0; i < 4; i++) put_byte(w[8*i +: 8]);
  endtask

  // Chunk header plus paylen payload bytes; mode forces bit 0 of the first byte of each cell.
  task automatic put_chunk(input logic [31:0] tag, input logic [31:0] size,
                           input int unsigned paylen, input flag_mode_t mode);
    logic [7:0] b;
    put_word(tag);
    put_word(size);
    for (int unsigned i = 0; i < paylen; i++) begin
      b = 8'($urandom);
      if (i % 8 == 0 && mode == FLAG_SET) b[0] = 1'b1;
      if (i % 8 == 0 && mode == FLAG_CLEAR) b[0] = 1'b0;
      put_byte(b);
    end
  endtask

  // One file of exactly flen bytes: header, random chunks, then trailing bytes; a noise file is random bytes only.
  task automatic put_file(input logic [31:0] flen, input file_kind_t kind);
    logic [95:0] head;
    logic [31:0] sz;
    int unsigned n;
    int unsigned room;
    int unsigned paylen;
    int unsigned pick;
    n = 0;
    if (kind == FILE_NOISE) begin
      while (n < flen) begin
        put_byte(8'($urandom));
        n++;
      end
      return;
    end
    head = {HEADER_VERSION, 32'd4, TAG_VERSION};
    if (kind == FILE_BAD_TAG) head[31:0] ^= 32'd1 << $urandom_range(0, 31);
    if (kind == FILE_BAD_VERSION) head[95:64] ^= 32'd1 << $urandom_range(0, 31);
    while (n < flen && n < 12) begin
      put_byte(head[8*n +: 8]);
      n++;
    end
    while (flen - n >= 8) begin
      room = flen - n - 8;
      pick = $urandom_range(0, 15);
      if (pick < 9) begin
        paylen = 8 * $urandom_range(0, (room / 8 < 6) ? room / 8 : 6);
        // Sometimes leave a partial cell at the end of the chunk.
        if (pick == 0) paylen += $urandom_range(0, (room - paylen < 7) ? room - paylen : 7);
        put_chunk(TAG_GRID, paylen, paylen, FLAG_RANDOM);
      end else if (pick < 11) begin
        paylen = $urandom_range(0, (room < 20) ? room : 20);
        put_chunk($urandom, paylen, paylen, FLAG_RANDOM);
      end else if (pick == 11) begin
        paylen = 0;
        put_chunk(TAG_GRID, 0, 0, FLAG_RANDOM);
      end else if (pick == 12) begin
        // Size that runs past the end of the file stops the walk.
        sz = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : room + 1 + $urandom_range(0, 50);
        put_chunk(TAG_GRID, sz, 0, FLAG_RANDOM);
        n += 8;
        break;
      end else begin
        paylen = room;
        put_chunk(TAG_GRID, room, room, FLAG_RANDOM);
      end
      n += 8 + paylen;
    end
    while (n < flen) begin
      put_byte(8'($urandom));
      n++;
    end
  endtask

  // Write the length register, then read it back.
  task automatic write_length(input logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= LEN_ADDR;
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== value) begin
      bad_results++;
      $display("%0t: stream length readback expected %h, got %h", $time, value, prdata);
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Hold the stimulus until every byte is taken and every result has come back.
  task automatic wait_idle();
    do @(negedge clk);
    while (bytes_taken != bytes_loaded || parser_results_due.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    logic [31:0] flen;
    int unsigned nfiles;
    int unsigned pick;
    file_kind_t kind;

    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    byte_ch.valid = 1'b0;
    byte_ch.data_byte = '0;
    result_ch.ready = 1'b0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // Length left at its reset value: good header alone, bad tag, bad version.
    put_file(12, FILE_GOOD);
    put_file(12, FILE_BAD_TAG);
    put_file(12, FILE_BAD_VERSION);
    wait_idle();

    // Length one and length zero: every byte ends a file that is too short.
    write_length(32'd1);
    put_byte(8'h00);
    put_byte(8'hFF);
    wait_idle();
    write_length(32'd0);
    put_byte(8'h5A);
    put_byte(8'hA5);
    wait_idle();

    // Too short wins over a bad tag.
    write_length(32'd11);
    put_file(11, FILE_GOOD);
    put_file(11, FILE_BAD_TAG);
    wait_idle();

    // Grid cells accumulate; other tags, empty chunks, partial cells, cut-off header.
    write_length(32'd91);
    put_file(12, FILE_GOOD);
    put_chunk(TAG_GRID, 24, 24, FLAG_SET);
    put_chunk(32'h5854_4554, 5, 5, FLAG_RANDOM);
    put_chunk(TAG_GRID, 0, 0, FLAG_RANDOM);
    put_chunk(TAG_GRID, 13, 13, FLAG_CLEAR);
    for (int i = 0; i < 5; i++) put_byte(8'($urandom));
    // Second file ends its walk on a chunk that overruns the file.
    put_file(12, FILE_GOOD);
    put_chunk(TAG_GRID, 16, 16, FLAG_RANDOM);
    put_chunk(TAG_GRID, 100, 0, FLAG_RANDOM);
    for (int i = 0; i < 47; i++) put_byte(8'($urandom));
    wait_idle();

    // Largest length: overrun is judged without wraparound, then the length is
    // lowered mid-file and the next byte closes it.
    write_length(32'hFFFF_FFFF);
    put_file(12, FILE_GOOD);
    put_chunk(TAG_GRID, 16, 16, FLAG_SET);
    put_chunk(TAG_GRID, 32'hFFFF_FFF0, 0, FLAG_RANDOM);
    for (int i = 0; i < 3; i++) put_byte(8'($urandom));
    wait_idle();
    write_length(32'd12);
    put_byte(8'($urandom));
    wait_idle();

    // Random phases: a length per phase, a few files each, mostly well formed.
    while (bytes_loaded < 760) begin
      if (bytes_loaded >= 620) no_idle = 1'b1;
      flen = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 11) : $urandom_range(12, 96);
      write_length(flen);
      nfiles = $urandom_range(1, 4);
      for (int unsigned f = 0; f < nfiles; f++) begin
        pick = $urandom_range(0, 9);
        kind = (pick < 7) ? FILE_GOOD : (pick == 7) ? FILE_BAD_TAG :
               (pick == 8) ? FILE_BAD_VERSION : FILE_NOISE;
        put_file(flen, kind);
      end
      wait_idle();
    end

    if (bad_results == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
